>>> rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Depends on nothing; rau_if, rau_dp, rau_ctrl and the top level import it.
package rau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FUNC_BITS     = 2;
   localparam int FIELD_BITS    = 32;
   localparam int DEN_BITS      = 31;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } rau_func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_ZERO_DEN = 2'd2,
      ST_OVERFLOW = 2'd3
   } rau_status_type;

   typedef enum logic [1:0] {
      MUL_T1,
      MUL_T2,
      MUL_T3
   } rau_mul_sel_type;

   typedef enum logic [1:0] {
      DIV_GCD,
      DIV_NUM,
      DIV_DEN
   } rau_div_src_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_COMB,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_NUM_WAIT,
      S_DEN_START,
      S_DEN_WAIT,
      S_CHECK,
      S_EMIT
   } rau_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            mul_en;
      rau_mul_sel_type mul_sel;
      logic            combine;
      logic            div_start;
      logic            div_take;
      rau_div_src_type div_src;
      logic            check;
      logic            emit;
   } rau_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic early_err;
      logic res_zero;
      logic y_zero;
      logic div_done;
      logic out_free;
   } rau_stat_type;

endpackage

>>> rtl/rau_if.sv
// Request and response channel interfaces of the rational arithmetic unit.
// Depends on rau_pkg for field widths.
interface rau_req_if;
   import rau_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [FUNC_BITS-1:0]         func;
   logic signed [FIELD_BITS-1:0] a_num;
   logic signed [FIELD_BITS-1:0] a_den;
   logic signed [FIELD_BITS-1:0] b_num;
   logic signed [FIELD_BITS-1:0] b_den;

   modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
   modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] res_num;
   logic [DEN_BITS-1:0]          res_den;
   logic [STATUS_BITS-1:0]       status;

   modport source(output valid, res_num, res_den, status, input ready);
   modport sink(input valid, res_num, res_den, status, output ready);
endinterface

>>> rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
module rau_div #(
   parameter int DIV_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quo,
   output logic [DIV_BITS-1:0] rem
);
   localparam int CW = $clog2(DIV_BITS + 1);

   logic                busy_ff, done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [DIV_BITS:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, div_ff;
   logic [DIV_BITS:0]   shifted, diff;
   logic                ge;

   assign shifted = {rem_ff[DIV_BITS-1:0], quo_ff[DIV_BITS-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};
   assign rem_in  = ge ? diff : shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_BITS-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[DIV_BITS-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < {1'b0, div_ff})) else $error("remainder not below divisor");
endmodule

>>> rtl/rau_dp.sv
// Datapath: operand split, shared multiplier, combine, Euclid registers,
// overflow check and the result register. Depends on rau_pkg and rau_div.
module rau_dp #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rau_pkg::rau_cmd_type                cmd,
   output rau_pkg::rau_stat_type               stat,
   input  logic [rau_pkg::FUNC_BITS-1:0]       in_func,
   input  logic [rau_pkg::FIELD_BITS-1:0]      in_a_num,
   input  logic [rau_pkg::FIELD_BITS-1:0]      in_a_den,
   input  logic [rau_pkg::FIELD_BITS-1:0]      in_b_num,
   input  logic [rau_pkg::FIELD_BITS-1:0]      in_b_den,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic signed [rau_pkg::FIELD_BITS-1:0] out_num,
   output logic [rau_pkg::DEN_BITS-1:0]        out_den,
   output logic [rau_pkg::STATUS_BITS-1:0]     out_status
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;
   localparam int P = 2 * WORD_BITS;
   localparam logic [P-1:0] LIM = P'(1) << (W - 1);

   function automatic logic [W-1:0] mag_of(input logic [FIELD_BITS-1:0] raw);
      logic [W-1:0] v;
      v = raw[W-1:0];
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   rau_func_type   func_ff;
   rau_status_type status_ff;
   logic [W-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic           sa_ff, sb_ff, rneg_ff;
   logic [P-1:0]   t1_ff, t2_ff, t3_ff;
   logic [P-1:0]   rmag_ff, rden_ff, x_ff, y_ff;
   logic           out_valid_ff;
   logic signed [FIELD_BITS-1:0] out_num_ff;
   logic [DEN_BITS-1:0]          out_den_ff;
   logic [STATUS_BITS-1:0]       out_status_ff;

   logic [W-1:0] mul_a, mul_b;
   logic [P-1:0] prod;
   logic         s2, cneg;
   logic [P-1:0] cmag, cden;
   logic [P-1:0] div_dividend, div_divisor, div_quo, div_rem;
   logic         div_done, ovf;
   logic signed [W-1:0] num_w;

   // One multiplier shared over the three products T1, T2 and T3.
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      unique case (cmd.mul_sel)
         MUL_T1: begin
            mul_a = an_ff;
            mul_b = (func_ff == FUNC_MUL) ? bn_ff : bd_ff;
         end
         MUL_T2: begin
            case (func_ff)
               FUNC_MUL: begin mul_a = ad_ff; mul_b = bd_ff; end
               FUNC_DIV: begin mul_a = ad_ff; mul_b = bn_ff; end
               default:  begin mul_a = bn_ff; mul_b = ad_ff; end
            endcase
         end
         MUL_T3: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end
   assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

   // Signed combination of the cross products.
   always_comb begin
      s2 = (func_ff == FUNC_SUB) ? !sb_ff : sb_ff;
      if (func_ff == FUNC_MUL || func_ff == FUNC_DIV) begin
         cmag = t1_ff;
         cden = t2_ff;
         cneg = sa_ff ^ sb_ff;
      end else begin
         cden = t3_ff;
         if (sa_ff == s2) begin
            cmag = t1_ff + t2_ff;
            cneg = sa_ff;
         end else if (t1_ff >= t2_ff) begin
            cmag = t1_ff - t2_ff;
            cneg = sa_ff;
         end else begin
            cmag = t2_ff - t1_ff;
            cneg = s2;
         end
      end
   end

   always_comb begin
      case (cmd.div_src)
         DIV_NUM: begin div_dividend = rmag_ff; div_divisor = x_ff; end
         DIV_DEN: begin div_dividend = rden_ff; div_divisor = x_ff; end
         default: begin div_dividend = x_ff;    div_divisor = y_ff; end
      endcase
   end

   rau_div #(.DIV_BITS(P)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign ovf = (|rden_ff[P-1:W-1]) || (rneg_ff ? (rmag_ff > LIM) : (rmag_ff >= LIM));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= rau_func_type'(in_func);
         an_ff   <= mag_of(in_a_num);
         ad_ff   <= mag_of(in_a_den);
         bn_ff   <= mag_of(in_b_num);
         bd_ff   <= mag_of(in_b_den);
         sa_ff   <= in_a_num[W-1] ^ in_a_den[W-1];
         sb_ff   <= in_b_num[W-1] ^ in_b_den[W-1];
         if (in_a_den[W-1:0] == '0 || in_b_den[W-1:0] == '0) begin
            status_ff <= ST_ZERO_DEN;
         end else if (rau_func_type'(in_func) == FUNC_DIV && in_b_num[W-1:0] == '0) begin
            status_ff <= ST_DIV_ZERO;
         end else begin
            status_ff <= ST_OK;
         end
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_T1:  t1_ff <= prod;
            MUL_T2:  t2_ff <= prod;
            default: t3_ff <= prod;
         endcase
      end
      if (cmd.combine) begin
         if (cmag == '0) begin
            rmag_ff <= '0;
            rden_ff <= P'(1);
            rneg_ff <= 1'b0;
         end else begin
            rmag_ff <= cmag;
            rden_ff <= cden;
            rneg_ff <= cneg;
         end
         x_ff <= cmag;
         y_ff <= cden;
      end
      if (cmd.div_take) begin
         case (cmd.div_src)
            DIV_NUM: rmag_ff <= div_quo;
            DIV_DEN: rden_ff <= div_quo;
            default: begin
               x_ff <= y_ff;
               y_ff <= div_rem;
            end
         endcase
      end
      if (cmd.check && ovf) begin
         status_ff <= ST_OVERFLOW;
      end
   end

   assign num_w = rneg_ff ? (~rmag_ff[W-1:0] + 1'b1) : rmag_ff[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= status_ff;
         if (status_ff == ST_OK) begin
            out_num_ff <= FIELD_BITS'(num_w);
            out_den_ff <= DEN_BITS'(rden_ff[W-1:0]);
         end else begin
            out_num_ff <= '0;
            out_den_ff <= '0;
         end
      end
   end

   assign stat.early_err = (status_ff != ST_OK);
   assign stat.res_zero  = (rmag_ff == '0);
   assign stat.y_zero    = (y_ff == '0);
   assign stat.div_done  = div_done;
   assign stat.out_free  = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign out_num    = out_num_ff;
   assign out_den    = out_den_ff;
   assign out_status = out_status_ff;
endmodule

>>> rtl/rau_ctrl.sv
// Controller state machine: sequences multiply, combine, Euclid steps,
// reduction divides, overflow check and result hand-off. Depends on rau_pkg.
module rau_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rau_pkg::rau_stat_type stat,
   output rau_pkg::rau_cmd_type  cmd
);
   import rau_pkg::*;

   rau_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_MUL1;
         S_MUL1:      state_in = stat.early_err ? S_EMIT : S_MUL2;
         S_MUL2:      state_in = S_MUL3;
         S_MUL3:      state_in = S_COMB;
         S_COMB:      state_in = S_GCD_TEST;
         S_GCD_TEST: begin
            if (stat.res_zero) begin
               state_in = S_CHECK;
            end else if (stat.y_zero) begin
               state_in = S_NUM_WAIT;
            end else begin
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT:  if (stat.div_done) state_in = S_GCD_TEST;
         S_NUM_WAIT:  if (stat.div_done) state_in = S_DEN_START;
         S_DEN_START: state_in = S_DEN_WAIT;
         S_DEN_WAIT:  if (stat.div_done) state_in = S_CHECK;
         S_CHECK:     state_in = S_EMIT;
         S_EMIT:      if (stat.out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T1;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T2;
         end
         S_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T3;
         end
         S_COMB:      cmd.combine = 1'b1;
         S_GCD_TEST: begin
            cmd.div_start = !stat.res_zero;
            cmd.div_src   = stat.y_zero ? DIV_NUM : DIV_GCD;
         end
         S_GCD_WAIT: begin
            cmd.div_src  = DIV_GCD;
            cmd.div_take = stat.div_done;
         end
         S_NUM_WAIT: begin
            cmd.div_src  = DIV_NUM;
            cmd.div_take = stat.div_done;
         end
         S_DEN_START: begin
            cmd.div_src   = DIV_DEN;
            cmd.div_start = 1'b1;
         end
         S_DEN_WAIT: begin
            cmd.div_src  = DIV_DEN;
            cmd.div_take = stat.div_done;
         end
         S_CHECK:     cmd.check = 1'b1;
         S_EMIT:      cmd.emit  = stat.out_free;
         default:     cmd = '0;
      endcase
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_en, cmd.combine, cmd.div_start, cmd.div_take,
                cmd.check, cmd.emit}))
      else $error("more than one datapath command in a cycle");
endmodule

>>> rtl/rational_arithmetic_unit.sv
// Each item's Euclid reduction takes k remainder steps; each step is one pass of the
// bit-serial divider. Errors detected at input skip to the result hand-off, and zero
// results skip the Euclid steps and reduction divides.
// Throughput: one item at a time; the next beat is taken once the previous result
// sits in the output register. Synchronous active-high reset empties that register.
//
// Top level of the rational arithmetic unit. Depends on rau_pkg, rau_if,
// rau_ctrl, rau_dp and rau_div.
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   // The controller walks the fixed multiply/combine steps and then loops
   // over Euclid remainder steps until the remainder is zero; the divider is
   // then reused twice to divide numerator and denominator by the gcd.
   rau_cmd_type  cmd;
   rau_stat_type stat;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the result register, so a finished beat can wait
   // on the response side while a new request is accepted.
   rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_func    (req.func),
      .in_a_num   (req.a_num),
      .in_a_den   (req.a_den),
      .in_b_num   (req.b_num),
      .in_b_den   (req.b_den),
      .out_ready  (rsp.ready),
      .out_valid  (rsp.valid),
      .out_num    (rsp.res_num),
      .out_den    (rsp.res_den),
      .out_status (rsp.status)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |-> (rsp.res_num == '0 && rsp.res_den == '0))
      else $error("error result carries nonzero fields");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_OK) |-> (rsp.res_den != '0))
      else $error("good result with zero denominator");
endmodule
